### hdl/bil_pkg.sv
// Package: word types and widths for the bilinear interpolator.
`timescale 1ns / 1ps
package bil_pkg;
    localparam int WORD_W = 32;
    localparam int SPAN_W = WORD_W + 1;
    localparam int PROD_W = SPAN_W + WORD_W;
    localparam int NUM_W  = 2 * WORD_W;

    typedef struct packed {
        logic signed [WORD_W-1:0] query_x;
        logic signed [WORD_W-1:0] query_y;
        logic signed [WORD_W-1:0] top_left_x;
        logic signed [WORD_W-1:0] top_left_y;
        logic signed [WORD_W-1:0] top_left_value;
        logic signed [WORD_W-1:0] top_right_x;
        logic signed [WORD_W-1:0] top_right_value;
        logic signed [WORD_W-1:0] bottom_left_x;
        logic signed [WORD_W-1:0] bottom_left_y;
        logic signed [WORD_W-1:0] bottom_left_value;
        logic signed [WORD_W-1:0] bottom_right_x;
        logic signed [WORD_W-1:0] bottom_right_value;
    } t_bil_in;

    typedef struct packed {
        logic signed [WORD_W-1:0] interpolated;
        logic                     span_error;
    } t_bil_out;
endpackage

### hdl/bilinear_interpolator_core.sv
// Top level: bilinear interpolation, two row steps in parallel then one column step.
//
//  channel  | ports                       | handshake
//  ---------+-----------------------------+---------------------------------
//  query    | start, busy, i_item         | taken when start & !busy
//  result   | o_done, o_result            | one-cycle strobe, no backpressure
//
// One word enters every cycle; busy is always low.
// Each of the two chained steps has 3 arithmetic stages, 64 divider bit stages and 1 round stage.
// Synchronous active-low reset clears only the valid bits.
// The receiver cannot stall, so nothing is ever held back.
`timescale 1ns / 1ps
module bilinear_interpolator_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  bil_pkg::t_bil_in  i_item,
    output logic              o_done,
    output bil_pkg::t_bil_out o_result
);
    import bil_pkg::*;

    logic                     top_valid, bot_valid, y_valid;
    logic signed [WORD_W-1:0] top_res, bot_res, y_res;
    logic                     top_zero, bot_zero, y_zero;
    logic [2*WORD_W-1:0]      top_side;
    logic [WORD_W-1:0]        bot_side;
    logic                     y_side;

    assign busy = 1'b0;

    bil_lerp #(.SIDE_W(2*WORD_W)) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start),
        .i_a0    (i_item.top_left_x),
        .i_a1    (i_item.top_right_x),
        .i_q     (i_item.query_x),
        .i_v0    (i_item.top_left_value),
        .i_v1    (i_item.top_right_value),
        .i_side  ({i_item.query_y, i_item.top_left_y}),
        .o_valid (top_valid),
        .o_res   (top_res),
        .o_zero  (top_zero),
        .o_side  (top_side)
    );

    bil_lerp #(.SIDE_W(WORD_W)) u_bot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start),
        .i_a0    (i_item.bottom_left_x),
        .i_a1    (i_item.bottom_right_x),
        .i_q     (i_item.query_x),
        .i_v0    (i_item.bottom_left_value),
        .i_v1    (i_item.bottom_right_value),
        .i_side  (i_item.bottom_left_y),
        .o_valid (bot_valid),
        .o_res   (bot_res),
        .o_zero  (bot_zero),
        .o_side  (bot_side)
    );

    bil_lerp #(.SIDE_W(1)) u_col (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (top_valid & bot_valid),
        .i_a0    (top_side[WORD_W-1:0]),
        .i_a1    (bot_side),
        .i_q     (top_side[2*WORD_W-1:WORD_W]),
        .i_v0    (top_res),
        .i_v1    (bot_res),
        .i_side  (top_zero | bot_zero),
        .o_valid (y_valid),
        .o_res   (y_res),
        .o_zero  (y_zero),
        .o_side  (y_side)
    );

    always_comb begin
        o_done                  = y_valid;
        o_result.span_error     = y_side | y_zero;
        o_result.interpolated   = (y_side | y_zero) ? '0 : y_res;
    end
endmodule

### hdl/bil_lerp.sv
// Pipelined one-axis interpolation step with restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
module bil_lerp #(
    parameter int SIDE_W = 1
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic signed [bil_pkg::WORD_W-1:0] i_a0,
    input  logic signed [bil_pkg::WORD_W-1:0] i_a1,
    input  logic signed [bil_pkg::WORD_W-1:0] i_q,
    input  logic signed [bil_pkg::WORD_W-1:0] i_v0,
    input  logic signed [bil_pkg::WORD_W-1:0] i_v1,
    input  logic        [SIDE_W-1:0]          i_side,
    output logic                              o_valid,
    output logic signed [bil_pkg::WORD_W-1:0] o_res,
    output logic                              o_zero,
    output logic        [SIDE_W-1:0]          o_side
);
    import bil_pkg::*;

    localparam logic [NUM_W:0] SAT_POS = {{(NUM_W-WORD_W+2){1'b0}}, {(WORD_W-1){1'b1}}};
    localparam logic [NUM_W:0] SAT_NEG = {{(NUM_W-WORD_W+1){1'b0}}, 1'b1, {(WORD_W-1){1'b0}}};

    // stage 1: spans
    logic                     r_v1;
    logic signed [SPAN_W-1:0] r_w0, r_w1, r_d;
    logic signed [WORD_W-1:0] r_val0, r_val1;
    logic        [SIDE_W-1:0] r_side1;
    // stage 2: products
    logic                     r_v2;
    logic signed [PROD_W-1:0] r_p0, r_p1;
    logic signed [SPAN_W-1:0] r_d2;
    logic        [SIDE_W-1:0] r_side2;

    // divider stages, index 0 is the entry
    logic                 r_dv   [0:NUM_W];
    logic [SPAN_W-1:0]    r_rem  [0:NUM_W];
    logic [NUM_W-1:0]     r_z    [0:NUM_W];
    logic [SPAN_W-1:0]    r_dm   [0:NUM_W];
    logic                 r_neg  [0:NUM_W];
    logic                 r_zr   [0:NUM_W];
    logic [SIDE_W-1:0]    r_sd   [0:NUM_W];

    logic signed [PROD_W:0]   n_sum;
    logic        [PROD_W:0]   n_mag;
    logic        [SPAN_W-1:0] n_dm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_dv[0] <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_dv[0] <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_w0    <= SPAN_W'(i_a1) - SPAN_W'(i_q);
        r_w1    <= SPAN_W'(i_q) - SPAN_W'(i_a0);
        r_d     <= SPAN_W'(i_a1) - SPAN_W'(i_a0);
        r_val0  <= i_v0;
        r_val1  <= i_v1;
        r_side1 <= i_side;
        r_p0    <= r_w0 * PROD_W'(r_val0);
        r_p1    <= r_w1 * PROD_W'(r_val1);
        r_d2    <= r_d;
        r_side2 <= r_side1;
    end

    always_comb begin
        n_sum = (PROD_W+1)'(r_p0) + (PROD_W+1)'(r_p1);
        n_mag = n_sum[PROD_W] ? -n_sum : n_sum;
        n_dm  = r_d2[SPAN_W-1] ? -r_d2 : r_d2;
    end

    always_ff @(posedge i_clk) begin
        r_rem[0] <= '0;
        r_z[0]   <= n_mag[NUM_W-1:0];
        r_dm[0]  <= n_dm;
        r_neg[0] <= n_sum[PROD_W] ^ r_d2[SPAN_W-1];
        r_zr[0]  <= (r_d2 == '0);
        r_sd[0]  <= r_side2;
    end

    genvar k;
    generate
        for (k = 0; k < NUM_W; k++) begin : g_div
            logic [SPAN_W:0] sh;
            logic [SPAN_W:0] df;
            always_comb begin
                sh = {r_rem[k], r_z[k][NUM_W-1]};
                df = sh - {1'b0, r_dm[k]};
            end
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_dv[k+1] <= 1'b0;
                end else begin
                    r_dv[k+1] <= r_dv[k];
                end
            end
            always_ff @(posedge i_clk) begin
                if (!df[SPAN_W]) begin
                    r_rem[k+1] <= df[SPAN_W-1:0];
                    r_z[k+1]   <= {r_z[k][NUM_W-2:0], 1'b1};
                end else begin
                    r_rem[k+1] <= sh[SPAN_W-1:0];
                    r_z[k+1]   <= {r_z[k][NUM_W-2:0], 1'b0};
                end
                r_dm[k+1]  <= r_dm[k];
                r_neg[k+1] <= r_neg[k];
                r_zr[k+1]  <= r_zr[k];
                r_sd[k+1]  <= r_sd[k];
            end
        end
    endgenerate

    // round half away from zero, then saturate
    logic [SPAN_W:0] n_rem2;
    logic [NUM_W:0]  n_quo;
    logic signed [WORD_W-1:0] n_res;

    always_comb begin
        n_rem2 = {r_rem[NUM_W], 1'b0};
        n_quo  = {1'b0, r_z[NUM_W]} + (NUM_W+1)'(n_rem2 >= {1'b0, r_dm[NUM_W]});
        if (r_neg[NUM_W]) begin
            if (n_quo >= SAT_NEG) begin
                n_res = {1'b1, {(WORD_W-1){1'b0}}};
            end else begin
                n_res = -n_quo[WORD_W-1:0];
            end
        end else begin
            if (n_quo > SAT_POS) begin
                n_res = {1'b0, {(WORD_W-1){1'b1}}};
            end else begin
                n_res = n_quo[WORD_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_dv[NUM_W];
        end
    end

    always_ff @(posedge i_clk) begin
        o_res  <= n_res;
        o_zero <= r_zr[NUM_W];
        o_side <= r_sd[NUM_W];
    end
endmodule

### bench/bil_checker.sv
// Checker: predicts each bilinear interpolation result and compares it with the block's output.
`timescale 1ns / 1ps
module bil_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  logic              busy,
    input  bil_pkg::t_bil_in  i_item,
    input  logic              o_done,
    input  bil_pkg::t_bil_out o_result,
    output int                o_fail_count,
    output int                o_pending,
    output int                o_checked,
    output int                o_span_errors
);
    import bil_pkg::*;

    t_bil_out expected_q[$];

    // one weighted step: round half away from zero, then saturate
    function automatic logic lerp_word(input logic signed [32:0] a0, input logic signed [32:0] a1,
                                       input logic signed [32:0] q, input logic signed [32:0] v0,
                                       input logic signed [32:0] v1,
                                       output logic signed [31:0] r);
        logic signed [71:0] n;
        logic signed [71:0] d;
        logic [71:0] nm;
        logic [71:0] dm;
        logic [71:0] quo;
        logic [71:0] rem;
        logic neg;
        r = '0;
        d = a1 - a0;
        if (d == 0) return 1'b0;
        n = (a1 - q) * v0 + (q - a0) * v1;
        neg = n[71] ^ d[71];
        nm = n[71] ? -n : n;
        dm = d[71] ? -d : d;
        quo = nm / dm;
        rem = nm % dm;
        if ((rem << 1) >= dm) quo = quo + 1;
        if (neg) begin
            if (quo >= 72'h80000000) r = 32'sh80000000;
            else r = -$signed(quo[31:0]);
        end else begin
            if (quo > 72'h7fffffff) r = 32'sh7fffffff;
            else r = quo[31:0];
        end
        return 1'b1;
    endfunction

    function automatic t_bil_out interpolate(input t_bil_in it);
        t_bil_out o;
        logic signed [31:0] top_row;
        logic signed [31:0] bottom_row;
        logic signed [31:0] val;
        logic ok_top;
        logic ok_bot;
        logic ok;
        ok_top = lerp_word(it.top_left_x, it.top_right_x, it.query_x,
                           it.top_left_value, it.top_right_value, top_row);
        ok_bot = lerp_word(it.bottom_left_x, it.bottom_right_x, it.query_x,
                           it.bottom_left_value, it.bottom_right_value, bottom_row);
        ok = ok_top && ok_bot;
        if (ok) ok = lerp_word(it.top_left_y, it.bottom_left_y, it.query_y,
                               top_row, bottom_row, val);
        o.interpolated = ok ? val : '0;
        o.span_error = !ok;
        return o;
    endfunction

    always @(posedge i_clk) begin
        t_bil_out want;
        if (!i_rst_n) begin
            expected_q.delete();
            o_fail_count <= 0;
            o_checked <= 0;
            o_span_errors <= 0;
        end else begin
            if (start && !busy) expected_q.push_back(interpolate(i_item));
            if (o_done) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected word: actual %h/%b", $time,
                             o_result.interpolated, o_result.span_error);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_q.pop_front();
                    o_checked <= o_checked + 1;
                    if (want.span_error) o_span_errors <= o_span_errors + 1;
                    if (want.interpolated !== o_result.interpolated
                            || want.span_error !== o_result.span_error) begin
                        $display("%0t: mismatch: expected %h/%b actual %h/%b", $time,
                                 want.interpolated, want.span_error,
                                 o_result.interpolated, o_result.span_error);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
        o_pending <= expected_q.size();
    end
endmodule

### bench/tb.sv
// Testbench top: drives queries into the bilinear interpolator and gives the verdict.
`timescale 1ns / 1ps
module tb;
    import bil_pkg::*;

    localparam int N_DIRECTED = 16;
    localparam int N_ITEMS    = 1850;
    localparam int LATENCY    = 136;
    localparam int LIMIT      = 200000;
    localparam logic signed [31:0] S_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] S_MIN = 32'sh80000000;
    localparam logic signed [31:0] ONE   = 32'sh00010000;

    logic     i_clk;
    logic     i_rst_n;
    logic     start;
    logic     busy;
    t_bil_in  i_item;
    logic     o_done;
    t_bil_out o_result;
    int       fail_count;
    int       pending;
    int       checked;
    int       span_errors;
    int       cycles = 0;
    int       accepted;

    bilinear_interpolator_core DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_item(i_item), .o_done(o_done), .o_result(o_result)
    );

    bil_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_item(i_item),
        .o_done(o_done), .o_result(o_result), .o_fail_count(fail_count),
        .o_pending(pending), .o_checked(checked), .o_span_errors(span_errors)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("** bilinear_interpolator_core: FAILED **");
            $finish;
        end
    end

    function automatic t_bil_in quad(input logic signed [31:0] qx,
                                     input logic signed [31:0] qy,
                                     input logic signed [31:0] x0, input logic signed [31:0] x1,
                                     input logic signed [31:0] y0, input logic signed [31:0] y1,
                                     input logic signed [31:0] v00, input logic signed [31:0] v01,
                                     input logic signed [31:0] v10, input logic signed [31:0] v11);
        t_bil_in it;
        it.query_x = qx;            it.query_y = qy;
        it.top_left_x = x0;         it.top_right_x = x1;
        it.bottom_left_x = x0;      it.bottom_right_x = x1;
        it.top_left_y = y0;         it.bottom_left_y = y1;
        it.top_left_value = v00;    it.top_right_value = v01;
        it.bottom_left_value = v10; it.bottom_right_value = v11;
        return it;
    endfunction

    function automatic t_bil_in rand_word_item();
        t_bil_in it;
        for (int i = 0; i < $bits(t_bil_in) / 32; i++) it[i*32 +: 32] = $urandom;
        return it;
    endfunction

    function automatic t_bil_in query_item(input int k);
        t_bil_in it;
        logic signed [31:0] x0;
        logic signed [31:0] y0;
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        int mode;
        case (k)
            0:  it = quad(ONE/2, ONE/2, 0, ONE, 0, ONE, ONE, 2*ONE, 3*ONE, 4*ONE);
            1:  begin it = quad(5, 5, 0, 9, 0, 9, 1, 2, 3, 4); it.top_right_x = 0; end
            2:  begin it = quad(5, 5, 0, 9, 0, 9, 1, 2, 3, 4); it.bottom_right_x = 0; end
            3:  it = quad(5, 5, 0, 9, 7, 7, 1, 2, 3, 4);
            4:  it = quad(S_MAX, S_MAX, S_MIN, S_MAX, S_MIN, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX);
            5:  it = quad(S_MIN, S_MIN, S_MIN, S_MAX, S_MIN, S_MAX, S_MIN, S_MIN, S_MIN, S_MIN);
            6:  it = quad(S_MAX, S_MAX, 0, 1, 0, 1, 0, S_MAX, 0, S_MAX);
            7:  it = quad(S_MAX, S_MAX, 0, 1, 0, 1, 0, S_MIN, 0, S_MIN);
            8:  it = quad(3*ONE, -ONE, 4*ONE, -4*ONE, ONE, -2*ONE, -ONE, 7*ONE, S_MAX, S_MIN);
            9:  it = quad(1, 0, 0, 2, 0, 1, 0, 1, 0, 1);
            10: it = quad(1, 0, 0, 2, 0, 1, 0, -1, 0, -1);
            11: it = quad(1, 0, 2, 0, 0, 1, 0, -3, 0, -3);
            12: it = quad(0, 0, -1, 1, -1, 1, 0, 0, 0, 0);
            13: it = quad(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1);
            14: it = quad(S_MIN, S_MAX, S_MAX, S_MIN, S_MAX, S_MIN, S_MIN, S_MAX, S_MAX, S_MIN);
            15: it = quad(0, 0, S_MIN, S_MAX, S_MAX, S_MIN, S_MAX, S_MIN, S_MIN, S_MAX);
            default: begin
                mode = $urandom_range(0, 9);
                if (mode < 2) begin
                    it = rand_word_item();
                end else if (mode == 2) begin
                    it = rand_word_item();
                    case ($urandom_range(0, 2))
                        0: it.top_right_x = it.top_left_x;
                        1: it.bottom_right_x = it.bottom_left_x;
                        default: it.bottom_left_y = it.top_left_y;
                    endcase
                end else begin
                    x0 = $urandom_range(0, 1) ? $signed($urandom)
                                              : $signed($urandom_range(0, 1 << 22)) - (1 << 21);
                    y0 = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
                    sx = $urandom_range(1, 1 << $urandom_range(1, 20));
                    sy = $urandom_range(1, 1 << $urandom_range(1, 20));
                    if ($urandom_range(0, 3) == 0) sx = -sx;
                    if ($urandom_range(0, 3) == 0) sy = -sy;
                    it = rand_word_item();
                    it.top_left_x = x0;        it.top_right_x = x0 + sx;
                    it.bottom_left_x = x0;     it.bottom_right_x = x0 + sx;
                    it.top_left_y = y0;        it.bottom_left_y = y0 + sy;
                    if ($urandom_range(0, 4) == 0) begin
                        it.bottom_left_x = x0 + $signed($urandom_range(0, 64)) - 32;
                        it.bottom_right_x = it.bottom_left_x + sx + 1;
                    end
                    it.query_x = x0 + $signed($urandom_range(0, sx < 0 ? -sx : sx))
                                 * (sx < 0 ? -1 : 1);
                    it.query_y = y0 + $signed($urandom_range(0, sy < 0 ? -sy : sy))
                                 * (sy < 0 ? -1 : 1);
                    if (mode == 3)
                        it.query_x = it.query_x + $signed($urandom_range(0, 1 << 24))
                                     - (1 << 23);
                    if (mode > 6) begin
                        it.top_left_value = $signed($urandom_range(0, 1 << 24)) - (1 << 23);
                        it.top_right_value = $signed($urandom_range(0, 1 << 24)) - (1 << 23);
                        it.bottom_left_value = $signed($urandom_range(0, 1 << 24)) - (1 << 23);
                        it.bottom_right_value = $signed($urandom_range(0, 1 << 24)) - (1 << 23);
                    end
                end
            end
        endcase
        return it;
    endfunction

    initial begin
        bit idle;
        accepted = 0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_item = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (accepted < N_ITEMS) begin
            @(posedge i_clk);
            if (start && !busy) accepted++;
            if (!(start && busy)) begin
                idle = (accepted < 800 || accepted > 1150) && ($urandom_range(0, 99) < 28);
                if (accepted >= N_ITEMS || idle) begin
                    start <= 1'b0;
                end else begin
                    start <= 1'b1;
                    i_item <= query_item(accepted);
                end
            end
        end
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 20) @(posedge i_clk);
        $display("%0d queries sent (%0d directed), %0d words checked, %0d with span error",
                 accepted, N_DIRECTED, checked, span_errors);
        if (fail_count == 0 && pending == 0)
            $display("** bilinear_interpolator_core: PASSED **");
        else
            $display("** bilinear_interpolator_core: FAILED **");
        $finish;
    end
endmodule
